// File: design/hsvrgb_pkg.sv
// ----------------------------------------------------------------------------
// hsvrgb_pkg
// Shared widths, defaults and hue sector codes for the HSV to RGB converter.
// ----------------------------------------------------------------------------
package hsvrgb_pkg;

    localparam int FRACTION_BITS_DEF = 15;

    localparam int HUE_W    = 15;
    localparam int LEVEL_W  = 16;
    localparam int COLOR_W  = 8;
    localparam int PACKED_W = 16;

    // Hexcone sector, hue times six, integer part
    typedef enum logic [2:0] {
        SECTOR_RED_YELLOW    = 3'd0,
        SECTOR_YELLOW_GREEN  = 3'd1,
        SECTOR_GREEN_CYAN    = 3'd2,
        SECTOR_CYAN_BLUE     = 3'd3,
        SECTOR_BLUE_MAGENTA  = 3'd4,
        SECTOR_MAGENTA_RED   = 3'd5
    } sector_t;

endpackage

// File: design/hsv_to_rgb_converter_core.sv
// ----------------------------------------------------------------------------
// hsv_to_rgb_converter_core
// Fixed-point hexcone HSV to RGB conversion, five-stage pipeline, one pixel
// per clock, 8-bit channels plus packed RGB565.
// ----------------------------------------------------------------------------
//   Channel | Direction | Handshake          | Payload
//   s_      | in        | s_valid / s_ready  | hue, saturation, brightness
//   m_      | out       | m_valid / m_ready  | red, green, blue, packed_565
//
//   One beat accepted per clock while the output side takes results.
//   Five register stages: clamp, f*s and (1-f)*s products, factor subtract,
//   level multiply, select. m_valid rises when a beat reaches the select
//   register, and the result is taken while m_ready is high.
//   The whole pipe advances on one enable: m_ready low with m_valid high
//   freezes every stage; s_ready is high whenever the output is empty or taken.
//   Reset clears the stage valid bits only.
// ----------------------------------------------------------------------------
module hsv_to_rgb_converter_core
    import hsvrgb_pkg::*;
#(
    parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [HUE_W-1:0]     s_hue,
    input  logic [LEVEL_W-1:0]   s_saturation,
    input  logic [LEVEL_W-1:0]   s_brightness,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [COLOR_W-1:0]   m_red,
    output logic [COLOR_W-1:0]   m_green,
    output logic [COLOR_W-1:0]   m_blue,
    output logic [PACKED_W-1:0]  m_packed_565
);

    localparam int F   = FRACTION_BITS;
    localparam int CW  = (F + 1 > LEVEL_W) ? F + 1 : LEVEL_W;
    localparam int VBW = F + 9;
    localparam int PW  = VBW + F + 1;
    localparam logic [F:0] ONE = {1'b1, {F{1'b0}}};

    logic advance;
    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg;

    assign advance = !v5_reg || m_ready;
    assign s_ready = advance;
    assign m_valid = v5_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end else if (advance) begin
            v1_reg <= s_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
        end
    end

    // ---------------- stage 1: clamp, sector split, 255*b ----------------
    logic [CW-1:0]  hue_ext, sat_ext, bri_ext;
    logic [F-1:0]   h;
    logic [F+2:0]   x;
    logic [F:0]     sat_c, bri_c;
    logic [2:0]     sector_next;
    logic [F-1:0]   f_next;
    logic [F:0]     omf_next, sat_next, oms_next;
    logic [VBW-1:0] vb_next;

    always_comb begin
        hue_ext     = CW'(s_hue);
        sat_ext     = CW'(s_saturation);
        bri_ext     = CW'(s_brightness);
        // hue wraps modulo one
        h           = hue_ext[F-1:0];
        x           = ({3'b000, h} << 2) + ({3'b000, h} << 1);
        sat_c       = (sat_ext > CW'(ONE)) ? ONE : sat_ext[F:0];
        bri_c       = (bri_ext > CW'(ONE)) ? ONE : bri_ext[F:0];
        sector_next = x[F+2:F];
        f_next      = x[F-1:0];
        omf_next    = ONE - {1'b0, x[F-1:0]};
        sat_next    = sat_c;
        oms_next    = ONE - sat_c;
        vb_next     = (VBW'(bri_c) << 8) - VBW'(bri_c);
    end

    logic [2:0]     sector1_reg;
    logic [F-1:0]   f1_reg;
    logic [F:0]     omf1_reg, sat1_reg, oms1_reg;
    logic [VBW-1:0] vb1_reg;

    // ---------------- stage 2: f*s and (1-f)*s ----------------
    logic [2*F:0]   fs_full;
    logic [2*F+1:0] ofs_full;
    logic [F:0]     fs_next, ofs_next;

    always_comb begin
        fs_full  = (2*F+1)'(f1_reg) * (2*F+1)'(sat1_reg);
        ofs_full = (2*F+2)'(omf1_reg) * (2*F+2)'(sat1_reg);
        fs_next  = fs_full[2*F:F];
        // (1-f)*s never exceeds one, top bit stays clear
        ofs_next = ofs_full[2*F:F];
    end

    logic [2:0]     sector2_reg;
    logic [F:0]     fs2_reg, ofs2_reg, oms2_reg;
    logic [VBW-1:0] vb2_reg;

    // ---------------- stage 3: q and t factors ----------------
    logic [F:0] kq_next, kt_next;

    assign kq_next = ONE - fs2_reg;
    assign kt_next = ONE - ofs2_reg;

    logic [2:0]     sector3_reg;
    logic [F:0]     kq3_reg, kt3_reg, oms3_reg;
    logic [VBW-1:0] vb3_reg;

    // ---------------- stage 4: levels ----------------
    logic [PW-1:0]      p_full, q_full, t_full;
    logic [COLOR_W-1:0] p_next, q_next, t_next, v_next;

    always_comb begin
        p_full = PW'(vb3_reg) * PW'(oms3_reg);
        q_full = PW'(vb3_reg) * PW'(kq3_reg);
        t_full = PW'(vb3_reg) * PW'(kt3_reg);
        p_next = p_full[2*F+7:2*F];
        q_next = q_full[2*F+7:2*F];
        t_next = t_full[2*F+7:2*F];
        v_next = vb3_reg[F+7:F];
    end

    logic [2:0]         sector4_reg;
    logic [COLOR_W-1:0] p4_reg, q4_reg, t4_reg, v4l_reg;

    // ---------------- stage 5: channel select and pack ----------------
    logic [COLOR_W-1:0] red_next, green_next, blue_next;

    always_comb begin
        case (sector_t'(sector4_reg))
            SECTOR_YELLOW_GREEN: begin
                red_next = q4_reg;  green_next = v4l_reg; blue_next = p4_reg;
            end
            SECTOR_GREEN_CYAN: begin
                red_next = p4_reg;  green_next = v4l_reg; blue_next = t4_reg;
            end
            SECTOR_CYAN_BLUE: begin
                red_next = p4_reg;  green_next = q4_reg;  blue_next = v4l_reg;
            end
            SECTOR_BLUE_MAGENTA: begin
                red_next = t4_reg;  green_next = p4_reg;  blue_next = v4l_reg;
            end
            SECTOR_MAGENTA_RED: begin
                red_next = v4l_reg; green_next = p4_reg;  blue_next = q4_reg;
            end
            default: begin
                red_next = v4l_reg; green_next = t4_reg;  blue_next = p4_reg;
            end
        endcase
    end

    logic [COLOR_W-1:0]  red_reg, green_reg, blue_reg;
    logic [PACKED_W-1:0] packed_reg;

    // payload advances with the valid bits, no reset needed
    always_ff @(posedge aclk) begin
        if (advance) begin
            sector1_reg <= sector_next;
            f1_reg      <= f_next;
            omf1_reg    <= omf_next;
            sat1_reg    <= sat_next;
            oms1_reg    <= oms_next;
            vb1_reg     <= vb_next;

            sector2_reg <= sector1_reg;
            fs2_reg     <= fs_next;
            ofs2_reg    <= ofs_next;
            oms2_reg    <= oms1_reg;
            vb2_reg     <= vb1_reg;

            sector3_reg <= sector2_reg;
            kq3_reg     <= kq_next;
            kt3_reg     <= kt_next;
            oms3_reg    <= oms2_reg;
            vb3_reg     <= vb2_reg;

            sector4_reg <= sector3_reg;
            p4_reg      <= p_next;
            q4_reg      <= q_next;
            t4_reg      <= t_next;
            v4l_reg     <= v_next;

            red_reg     <= red_next;
            green_reg   <= green_next;
            blue_reg    <= blue_next;
            packed_reg  <= {red_next[7:3], green_next[7:2], blue_next[7:3]};
        end
    end

    assign m_red        = red_reg;
    assign m_green      = green_reg;
    assign m_blue       = blue_reg;
    assign m_packed_565 = packed_reg;

endmodule

// File: design/hsvrgb_checker.sv
// ----------------------------------------------------------------------------
// hsvrgb_checker
// Port-level checks for the HSV to RGB converter, bound to the top level.
// ----------------------------------------------------------------------------
module hsvrgb_checker
    import hsvrgb_pkg::*;
(
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 s_ready,
    input logic                 m_valid,
    input logic                 m_ready,
    input logic [COLOR_W-1:0]   m_red,
    input logic [COLOR_W-1:0]   m_green,
    input logic [COLOR_W-1:0]   m_blue,
    input logic [PACKED_W-1:0]  m_packed_565
);

    // reset empties the pipe
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("m_valid high after reset");

    // a stalled result beat holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_red) && $stable(m_green)
                                && $stable(m_blue) && $stable(m_packed_565))
        else $error("result beat changed under stall");

    // packed word follows the channels
    a_pack: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_packed_565 == {m_red[7:3], m_green[7:2], m_blue[7:3]})
        else $error("packed_565 does not match channels");

    // an empty or draining output lets the pipe advance
    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        (!m_valid || m_ready) |-> s_ready)
        else $error("s_ready low while output can drain");

endmodule

bind hsv_to_rgb_converter_core hsvrgb_checker u_hsvrgb_checker (
    .aclk         (aclk),
    .aresetn      (aresetn),
    .s_ready      (s_ready),
    .m_valid      (m_valid),
    .m_ready      (m_ready),
    .m_red        (m_red),
    .m_green      (m_green),
    .m_blue       (m_blue),
    .m_packed_565 (m_packed_565)
);

// File: tb/hsv_to_rgb_converter_checker.sv
// ----------------------------------------------------------------------------
// hsv_to_rgb_converter_checker
// Watches both channels of the HSV to RGB converter. Each accepted input beat
// is turned into the expected red, green, blue and RGB565 values. Each result
// beat is then compared field by field, in order, against the oldest one.
// ----------------------------------------------------------------------------
module hsv_to_rgb_converter_checker
    import hsvrgb_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    input  logic                 s_ready,
    input  logic [HUE_W-1:0]     s_hue,
    input  logic [LEVEL_W-1:0]   s_saturation,
    input  logic [LEVEL_W-1:0]   s_brightness,
    input  logic                 m_valid,
    input  logic                 m_ready,
    input  logic [COLOR_W-1:0]   m_red,
    input  logic [COLOR_W-1:0]   m_green,
    input  logic [COLOR_W-1:0]   m_blue,
    input  logic [PACKED_W-1:0]  m_packed_565,
    output int                   mismatch_count,
    output int                   colors_pending,
    output int                   colors_checked,
    output int                   inputs_above_one
);

    localparam int              FB    = FRACTION_BITS_DEF;
    localparam longint unsigned UNITY = 64'd1 << FB;

    typedef struct packed {
        logic [COLOR_W-1:0]  red;
        logic [COLOR_W-1:0]  green;
        logic [COLOR_W-1:0]  blue;
        logic [PACKED_W-1:0] rgb565;
    } rgb_color_t;

    typedef struct {
        int                 index;
        logic [HUE_W-1:0]   hue;
        logic [LEVEL_W-1:0] saturation;
        logic [LEVEL_W-1:0] brightness;
        rgb_color_t         color;
    } pending_color_t;

    pending_color_t pending_colors[$];
    pending_color_t oldest;
    int             pixel_index;
    int             mismatch_total;

    assign mismatch_count = mismatch_total;

    // 255 * brightness * factor, both Q1.F, truncated to an integer level
    function automatic longint unsigned channel_level(longint unsigned val,
                                                      longint unsigned factor);
        return (64'd255 * val * factor) >> (2 * FB);
    endfunction

    function automatic rgb_color_t hsv_to_color(logic [HUE_W-1:0]   hue,
                                                logic [LEVEL_W-1:0] sat_in,
                                                logic [LEVEL_W-1:0] val_in);
        longint unsigned h, s, b, x, f, v, p, q, t;
        sector_t         sector;
        logic [7:0]      r, g, bl;
        rgb_color_t      color;

        h = hue & (UNITY - 1);
        s = (sat_in > UNITY) ? UNITY : sat_in;
        b = (val_in > UNITY) ? UNITY : val_in;
        x = h * 6;
        sector = sector_t'(x >> FB);
        f = x & (UNITY - 1);

        v = (64'd255 * b) >> FB;
        p = channel_level(b, UNITY - s);
        q = channel_level(b, UNITY - ((f * s) >> FB));
        t = channel_level(b, UNITY - (((UNITY - f) * s) >> FB));

        case (sector)
            SECTOR_YELLOW_GREEN: begin r = q[7:0]; g = v[7:0]; bl = p[7:0]; end
            SECTOR_GREEN_CYAN:   begin r = p[7:0]; g = v[7:0]; bl = t[7:0]; end
            SECTOR_CYAN_BLUE:    begin r = p[7:0]; g = q[7:0]; bl = v[7:0]; end
            SECTOR_BLUE_MAGENTA: begin r = t[7:0]; g = p[7:0]; bl = v[7:0]; end
            SECTOR_MAGENTA_RED:  begin r = v[7:0]; g = p[7:0]; bl = q[7:0]; end
            default:             begin r = v[7:0]; g = t[7:0]; bl = p[7:0]; end
        endcase

        color.red    = r;
        color.green  = g;
        color.blue   = bl;
        color.rgb565 = {r[7:3], g[7:2], bl[7:3]};
        return color;
    endfunction

    task automatic report_mismatch(string msg);
        $display("[%0t] MISMATCH: %s", $time, msg);
        mismatch_total++;
    endtask

    task automatic check_field(string name, int got, int want);
        if (got != want)
            report_mismatch($sformatf("pixel %0d (h=%0d s=%0d v=%0d): %s %0d, expected %0d",
                oldest.index, oldest.hue, oldest.saturation, oldest.brightness,
                name, got, want));
    endtask

    initial begin
        mismatch_total   = 0;
        colors_pending   = 0;
        colors_checked   = 0;
        inputs_above_one = 0;
        pixel_index      = 0;
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (pending_colors.size() == 0) begin
                    report_mismatch($sformatf("result beat r=%0d g=%0d b=%0d with none pending",
                        m_red, m_green, m_blue));
                end else begin
                    oldest = pending_colors.pop_front();
                    check_field("red",    m_red,        oldest.color.red);
                    check_field("green",  m_green,      oldest.color.green);
                    check_field("blue",   m_blue,       oldest.color.blue);
                    check_field("rgb565", m_packed_565, oldest.color.rgb565);
                    colors_checked++;
                end
            end
            if (s_valid && s_ready) begin
                pending_colors.push_back('{pixel_index, s_hue, s_saturation, s_brightness,
                    hsv_to_color(s_hue, s_saturation, s_brightness)});
                if (s_saturation > UNITY || s_brightness > UNITY)
                    inputs_above_one++;
                pixel_index++;
            end
            colors_pending = pending_colors.size();
        end
    end

endmodule

// File: tb/hsv_to_rgb_converter_core_test.sv
// ----------------------------------------------------------------------------
// hsv_to_rgb_converter_core_test
// Drives HSV pixels into the converter: directed corners and sector borders
// first, then random pixels with bursts of idle on both sides, one long output
// stall that backs up the pipe, and a final stretch at full rate.
// ----------------------------------------------------------------------------
module hsv_to_rgb_converter_core_test;
    import hsvrgb_pkg::*;

    localparam int RANDOM_PIXELS = 925;
    localparam int TAIL_PIXELS   = 200;
    localparam int PHASE_PIXELS  = 120;
    localparam int LONG_HOLD     = 80;
    localparam int STALL_LIMIT   = 1000;
    localparam int DRAIN_CYCLES  = 12;

    logic                 aclk;
    logic                 aresetn;
    logic                 s_valid;
    logic                 s_ready;
    logic [HUE_W-1:0]     s_hue;
    logic [LEVEL_W-1:0]   s_saturation;
    logic [LEVEL_W-1:0]   s_brightness;
    logic                 m_valid;
    logic                 m_ready;
    logic [COLOR_W-1:0]   m_red;
    logic [COLOR_W-1:0]   m_green;
    logic [COLOR_W-1:0]   m_blue;
    logic [PACKED_W-1:0]  m_packed_565;

    int mismatch_count;
    int colors_pending;
    int colors_checked;
    int inputs_above_one;

    int idle_odds;
    bit quiet_tail;
    bit long_hold_req;
    int pixels_sent;
    int directed_pixels;
    int stall_cycles;

    hsv_to_rgb_converter_core dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_hue        (s_hue),
        .s_saturation (s_saturation),
        .s_brightness (s_brightness),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_red        (m_red),
        .m_green      (m_green),
        .m_blue       (m_blue),
        .m_packed_565 (m_packed_565)
    );

    hsv_to_rgb_converter_checker u_checker (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_hue            (s_hue),
        .s_saturation     (s_saturation),
        .s_brightness     (s_brightness),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_red            (m_red),
        .m_green          (m_green),
        .m_blue           (m_blue),
        .m_packed_565     (m_packed_565),
        .mismatch_count   (mismatch_count),
        .colors_pending   (colors_pending),
        .colors_checked   (colors_checked),
        .inputs_above_one (inputs_above_one)
    );

    always #5 aclk = ~aclk;

    // Call at a falling edge; returns at the falling edge after the beat
    task automatic offer_pixel(input logic [HUE_W-1:0] h, input logic [LEVEL_W-1:0] sat,
                               input logic [LEVEL_W-1:0] val);
        int gap;
        gap = 0;
        if (idle_odds != 0 && $urandom_range(0, idle_odds - 1) == 0)
            gap = $urandom_range(1, 9);
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid      <= 1'b1;
        s_hue        <= h;
        s_saturation <= sat;
        s_brightness <= val;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        @(negedge aclk);
        pixels_sent++;
    endtask

    function automatic logic [LEVEL_W-1:0] corner_level();
        case ($urandom_range(0, 5))
            0:       return 16'd0;
            1:       return 16'd1;
            2:       return 16'd32767;
            3:       return 16'd32768;
            4:       return 16'd32769;
            default: return 16'hFFFF;
        endcase
    endfunction

    // Watchdog: count cycles without any beat on either side
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready))
                stall_cycles <= 0;
            else
                stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("Timeout: no beat for %0d cycles, %0d results pending",
                    stall_cycles, colors_pending);
                $display("Mismatches found");
                $finish;
            end
        end
    end

    // Receiver: random hold-off bursts, one long hold, none in the tail
    initial begin
        wait (aresetn === 1'b1);
        while (!quiet_tail) begin
            @(negedge aclk);
            if (long_hold_req) begin
                m_ready <= 1'b0;
                repeat (LONG_HOLD) @(negedge aclk);
                m_ready <= 1'b1;
                long_hold_req = 1'b0;
            end else if (idle_odds != 0 && $urandom_range(0, idle_odds - 1) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 9)) @(negedge aclk);
                m_ready <= 1'b1;
            end else begin
                m_ready <= 1'b1;
            end
        end
        @(negedge aclk);
        m_ready <= 1'b1;
    end

    initial begin
        int phase_odds[5];
        int pick;
        logic [LEVEL_W-1:0] sat, val;

        phase_odds    = '{4, 0, 2, 8, 3};
        aclk          = 1'b0;
        aresetn       = 1'b0;
        s_valid       = 1'b0;
        s_hue         = '0;
        s_saturation  = '0;
        s_brightness  = '0;
        m_ready       = 1'b0;
        idle_odds     = 3;
        quiet_tail    = 1'b0;
        long_hold_req = 1'b0;
        pixels_sent   = 0;
        stall_cycles  = 0;

        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Full brightness with no saturation, then field extremes
        offer_pixel(15'd0,     16'd0,     16'd32768);
        offer_pixel(15'd0,     16'd32768, 16'd32768);
        offer_pixel(15'd0,     16'd0,     16'd0);
        offer_pixel(15'd32767, 16'hFFFF,  16'hFFFF);
        offer_pixel(15'd32767, 16'd0,     16'hFFFF);
        offer_pixel(15'd7000,  16'hFFFF,  16'd0);
        offer_pixel(15'd12345, 16'd32769, 16'd32769);
        offer_pixel(15'd20000, 16'd32767, 16'd32767);
        offer_pixel(15'd1,     16'd1,     16'd1);
        offer_pixel(15'h5555,  16'h5555,  16'hAAAA);
        offer_pixel(15'h2AAA,  16'hAAAA,  16'h5555);
        offer_pixel(15'd30000, 16'd16384, 16'd49152);
        // Sector borders on both sides, full saturation but for the last at half
        offer_pixel(15'd5461,  16'd32768, 16'd32768);
        offer_pixel(15'd5462,  16'd32768, 16'd32768);
        offer_pixel(15'd10922, 16'd32768, 16'd32768);
        offer_pixel(15'd10923, 16'd32768, 16'd32768);
        offer_pixel(15'd16383, 16'd32768, 16'd32768);
        offer_pixel(15'd16384, 16'd32768, 16'd32768);
        offer_pixel(15'd21845, 16'd32768, 16'd32768);
        offer_pixel(15'd21846, 16'd32768, 16'd32768);
        offer_pixel(15'd27306, 16'd32768, 16'd32768);
        offer_pixel(15'd27307, 16'd32768, 16'd32768);
        offer_pixel(15'd32767, 16'd16384, 16'd32768);
        directed_pixels = pixels_sent;

        // Back up the pipe once while the sender keeps offering
        long_hold_req = 1'b1;

        for (int i = 0; i < RANDOM_PIXELS; i++) begin
            if (i == RANDOM_PIXELS - TAIL_PIXELS) begin
                idle_odds  = 0;
                quiet_tail = 1'b1;
            end else if (i < RANDOM_PIXELS - TAIL_PIXELS && i % PHASE_PIXELS == 0) begin
                idle_odds = phase_odds[(i / PHASE_PIXELS) % 5];
            end
            pick = $urandom_range(0, 9);
            if (pick < 6) begin
                sat = LEVEL_W'($urandom_range(0, 32768));
                val = LEVEL_W'($urandom_range(0, 32768));
            end else if (pick < 8) begin
                sat = ($urandom_range(0, 1) == 0) ? corner_level()
                                                  : LEVEL_W'($urandom_range(0, 32768));
                val = ($urandom_range(0, 1) == 0) ? corner_level()
                                                  : LEVEL_W'($urandom_range(0, 32768));
            end else begin
                sat = LEVEL_W'($urandom_range(0, 65535));
                val = LEVEL_W'($urandom_range(0, 65535));
            end
            offer_pixel(HUE_W'($urandom_range(0, 32767)), sat, val);
        end
        s_valid <= 1'b0;

        while (colors_pending != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("Converted %0d pixels (%0d directed), %0d results compared field by field",
            pixels_sent, directed_pixels, colors_checked);
        $display("Inputs clamped above 1.0: %0d; one output stall of %0d cycles filled the pipe",
            inputs_above_one, LONG_HOLD);
        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
